/* hdl/x86bcj_pkg.sv */
// ----------------------------------------------------------------------------
// x86bcj_pkg
// Constants, types and helpers for the x86 branch/call/jump stream filter.
// ----------------------------------------------------------------------------
package x86bcj_pkg;

  localparam int WinLen    = 5;
  localparam int FifoDepth = 16;
  localparam int FifoAw    = $clog2(FifoDepth);

  localparam logic [7:0]  OPC_MASK   = 8'hFE;  // E8 and E9 differ in bit 0
  localparam logic [7:0]  OPC_CALL   = 8'hE8;
  localparam logic [7:0]  SIGN_ZERO  = 8'h00;
  localparam logic [7:0]  SIGN_ONES  = 8'hFF;
  localparam logic [31:0] POS_BIAS   = 32'd5;  // position of the byte after the call
  localparam logic [1:0]  GAP_MAX    = 2'd3;
  localparam logic [2:0]  MASK_SEEN  = 3'd4;

  // register indexes on the write port
  localparam logic REG_DIRECTION    = 1'b0;
  localparam logic REG_START_OFFSET = 1'b1;

  // which byte of the converted word decides the second correction
  typedef enum logic [1:0] {
    CORR_NONE,
    CORR_B0,
    CORR_B1,
    CORR_B2
  } corr_t;

  // one accepted byte's worth of output, carried down the pipeline
  typedef struct packed {
    logic [WinLen-1:0][7:0] bytes;  // window after insert, head at [0]
    logic [2:0]             cnt;    // bytes to emit, 0..5
    logic                   last;   // tag the final emitted byte
    logic                   conv;   // bytes 1..4 replaced by converted word
    logic                   dir;    // 1 add, 0 subtract
    corr_t                  corr;
    logic [31:0]            cur;    // start offset + 5 + position
    logic [31:0]            val;    // displacement, converted once after stage B
  } rec_t;

  function automatic logic sign_like(input logic [7:0] b);
    sign_like = (b == SIGN_ZERO) || (b == SIGN_ONES);
  endfunction

endpackage

/* hdl/x86_branch_call_filter.sv */
// ----------------------------------------------------------------------------
// x86_branch_call_filter
// Streaming x86 BCJ filter: converts E8/E9 call/jump displacements between
// relative and absolute form, one byte per word on both streams.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                         | handshake
//  ---------+-----+---------------------------------+---------------------------
//  s_axis   | in  | tdata[7:0] in_byte, tlast=last  | tvalid/tready
//  m_axis   | out | tdata[7:0] out_byte, tlast=last | tvalid/tready
//  cfg      | in  | idx 0 direction, 1 start_offset | cfg_we, one-cycle write
//
// One input word per cycle while s_axis_tready is high. Each accepted word
// yields 0..5 output words; the total out equals the total in, so one byte
// per cycle sustains end to end while m_axis_tready stays high. Work runs in
// three stages (window/state update, first add, correction add) into a
// 16-entry output FIFO; a word's output is registered in rec_b, then rec_c.
// s_axis_tready is registered and drops while FIFO plus in-flight words
// exceed 11, i.e. while room for a full five-word burst is not guaranteed.
// rst is synchronous, active high; it empties window, pipeline and FIFO.
// ----------------------------------------------------------------------------
module x86_branch_call_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import x86bcj_pkg::*;

  // configuration
  logic        direction;
  logic [31:0] start_offset;

  // stream state
  logic [7:0]  win [WinLen];
  logic [2:0]  fill;         // 0..4 between words
  logic [2:0]  opc_mask;
  logic [1:0]  gap;
  logic [31:0] pos5;         // stream position of head plus 5

  // stage A combinational
  logic [7:0]  w [WinLen];
  logic [7:0]  win_next [WinLen];
  logic [2:0]  fill_next;
  logic [2:0]  opc_mask_next;
  logic [1:0]  gap_next;
  logic [31:0] pos5_next;
  logic        examine, is_op, skip, conv, pass;
  logic [2:0]  m;
  logic [7:0]  probe;
  logic [2:0]  cnt_a;
  corr_t       corr_a;
  logic        acc;

  // pipeline
  rec_t        rec_a, rec_b, rec_bv, rec_c;
  logic        vb, vc;

  // output FIFO
  logic [8:0]        fifo [FifoDepth];   // {last, byte}
  logic [FifoAw-1:0] wr_ptr, rd_ptr;
  logic [FifoAw:0]   fcount, fcount_next;
  logic [FifoAw:0]   occ, occ_next;     // FIFO plus words still in flight
  logic              pop;

  // stage C combinational
  logic [31:0] v2;
  logic [7:0]  corr_byte;
  logic [31:0] corr_xor;
  logic        do_corr;
  logic [7:0]  ob [WinLen];

  assign acc = s_axis_tvalid & s_axis_tready;
  assign pop = m_axis_tvalid & m_axis_tready;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      direction    <= 1'b0;
      start_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIRECTION:    direction    <= cfg_data[0];
        REG_START_OFFSET: start_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- stage A: window and state ----------------
  always_comb begin
    for (int i = 0; i < WinLen; i++) begin
      w[i] = (fill == 3'(i)) ? s_axis_tdata : win[i];
    end
    examine       = (fill == 3'(WinLen - 1));
    is_op         = (w[0] & OPC_MASK) == OPC_CALL;
    win_next      = w;
    fill_next     = fill + 3'd1;
    opc_mask_next = opc_mask;
    gap_next      = gap;
    pos5_next     = pos5;
    m             = '0;
    skip          = 1'b0;
    conv          = 1'b0;
    pass          = 1'b0;
    corr_a        = CORR_NONE;
    cnt_a         = s_axis_tlast ? fill + 3'd1 : 3'd0;

    // byte that vetoes a conversion after a recent opcode
    case (opc_mask[2:1])
      2'd0:    probe = w[1];
      2'd1:    probe = w[2];
      2'd2:    probe = w[3];
      default: probe = w[0];
    endcase

    if (examine) begin
      if (!is_op) begin
        gap_next = (gap == GAP_MAX) ? GAP_MAX : gap + 2'd1;
        pass     = 1'b1;
      end else begin
        gap_next = '0;
        if (gap != GAP_MAX) begin
          m = opc_mask >> gap;
          case (m[2:1])
            2'd0:    probe = w[1];
            2'd1:    probe = w[2];
            2'd2:    probe = w[3];
            default: probe = w[0];
          endcase
          skip = (m != 3'd0) && ((m > 3'd4) || (m == 3'd3) || sign_like(probe));
        end
        if (!skip && sign_like(w[WinLen-1])) begin
          conv = 1'b1;
        end else begin
          pass          = 1'b1;
          opc_mask_next = (m >> 1) | MASK_SEEN;
        end
      end
    end

    if (conv) begin
      fill_next     = '0;
      opc_mask_next = '0;
      pos5_next     = pos5 + 32'(WinLen);
      cnt_a         = 3'(WinLen);
      case (m)
        3'd1:    corr_a = CORR_B0;
        3'd2:    corr_a = CORR_B1;
        3'd4:    corr_a = CORR_B2;
        default: corr_a = CORR_NONE;
      endcase
    end

    if (pass) begin
      for (int i = 0; i < WinLen - 1; i++) begin
        win_next[i] = w[i+1];
      end
      win_next[WinLen-1] = '0;
      fill_next          = 3'(WinLen - 1);
      pos5_next          = pos5 + 32'd1;
      cnt_a              = s_axis_tlast ? 3'(WinLen) : 3'd1;
    end

    // end of stream: everything held is flushed, state starts over
    if (s_axis_tlast) begin
      fill_next     = '0;
      opc_mask_next = '0;
      gap_next      = '0;
      pos5_next     = POS_BIAS;
    end
  end

  // record handed to stage B
  always_comb begin
    for (int i = 0; i < WinLen; i++) begin
      rec_a.bytes[i] = w[i];
    end
    rec_a.cnt  = cnt_a;
    rec_a.last = s_axis_tlast;
    rec_a.conv = conv;
    rec_a.dir  = direction;
    rec_a.corr = corr_a;
    rec_a.cur  = start_offset + pos5;
    rec_a.val  = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      opc_mask <= '0;
      gap      <= '0;
      pos5     <= POS_BIAS;
      vb       <= 1'b0;
    end else begin
      vb <= acc;
      if (acc) begin
        fill     <= fill_next;
        opc_mask <= opc_mask_next;
        gap      <= gap_next;
        pos5     <= pos5_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      win   <= win_next;
      rec_b <= rec_a;
    end
  end

  // ---------------- stage B: first conversion ----------------
  always_comb begin
    rec_bv     = rec_b;
    rec_bv.val = rec_b.dir ? rec_b.bytes[4:1] + rec_b.cur
                           : rec_b.bytes[4:1] - rec_b.cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (vb) begin
      rec_c <= rec_bv;
    end
  end

  // ---------------- stage C: second correction ----------------
  always_comb begin
    case (rec_c.corr)
      CORR_B1: begin
        corr_byte = rec_c.val[15:8];
        corr_xor  = 32'h0000_FFFF;
      end
      CORR_B2: begin
        corr_byte = rec_c.val[23:16];
        corr_xor  = 32'h00FF_FFFF;
      end
      default: begin
        corr_byte = rec_c.val[7:0];
        corr_xor  = 32'h0000_00FF;
      end
    endcase
    do_corr = (rec_c.corr != CORR_NONE) && sign_like(corr_byte);
    if (do_corr) begin
      v2 = rec_c.dir ? (rec_c.val ^ corr_xor) + rec_c.cur
                     : (rec_c.val ^ corr_xor) - rec_c.cur;
    end else begin
      v2 = rec_c.val;
    end
    for (int i = 0; i < WinLen; i++) begin
      ob[i] = rec_c.bytes[i];
    end
    if (rec_c.conv) begin
      ob[1] = v2[7:0];
      ob[2] = v2[15:8];
      ob[3] = v2[23:16];
      ob[4] = v2[24] ? SIGN_ONES : SIGN_ZERO;
    end
  end

  // ---------------- output FIFO ----------------
  always_comb begin
    fcount_next = fcount - {{FifoAw{1'b0}}, pop};
    occ_next    = occ - {{FifoAw{1'b0}}, pop};
    if (vc) begin
      fcount_next = fcount_next + (FifoAw + 1)'(rec_c.cnt);
    end
    if (acc) begin
      occ_next = occ_next + (FifoAw + 1)'(cnt_a);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      fcount        <= '0;
      occ           <= '0;
      s_axis_tready <= 1'b0;
    end else begin
      fcount        <= fcount_next;
      occ           <= occ_next;
      s_axis_tready <= occ_next <= (FifoAw + 1)'(FifoDepth - WinLen);
      if (pop) begin
        rd_ptr <= rd_ptr + FifoAw'(1);
      end
      if (vc) begin
        wr_ptr <= wr_ptr + FifoAw'(rec_c.cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vc) begin
      for (int i = 0; i < WinLen; i++) begin
        if (3'(i) < rec_c.cnt) begin
          fifo[wr_ptr + FifoAw'(i)] <= {rec_c.last && (3'(i + 1) == rec_c.cnt), ob[i]};
        end
      end
    end
  end

  assign m_axis_tvalid = (fcount != '0);
  assign m_axis_tdata  = fifo[rd_ptr][7:0];
  assign m_axis_tlast  = fifo[rd_ptr][8];

endmodule

/* bench/x86_branch_call_filter_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// x86_branch_call_filter_test
// Self-checking bench for the streaming x86 call/jump filter. A directed table
// covers short streams, conversions, mask skips and byte extremes. Random
// streams then run under several direction/offset settings with random stalls
// on both streams. Output is checked against an in-bench model or typed rows.
// ----------------------------------------------------------------------------
module x86_branch_call_filter_test;
  import x86bcj_pkg::*;

  // one output word: filtered byte plus end-of-stream tag
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  // one row of stimulus; typed rows carry their own expected bytes
  typedef struct packed {
    logic [7:0]      b;
    logic            l;
    logic            typed;
    logic [2:0]      n;
    logic [4:0][7:0] outs;   // outs[0] comes out first
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] in_byte
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] out_byte
  logic        m_axis_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  x86_branch_call_filter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // bench-side copy of registers and filter state
  logic        fwd;            // 1 relative->absolute, 0 absolute->relative
  logic [31:0] base;           // stream position of the first byte
  logic [7:0]  win [WinLen];   // lookahead, head at [0]
  int          held;           // bytes in win
  logic [2:0]  call_mask;      // recent E8/E9 history
  logic [1:0]  gap;            // non-call heads since last call, saturating
  logic [31:0] pos;            // stream position of the head

  out_word_t   step_words[$];  // words caused by the latest input word
  out_word_t   pending_out[$]; // words still owed by the block
  stim_row_t   plan [25];
  bit          calm;           // no idling on either side when set
  int          fail_count;

  // --------------------------------------------------------------------------
  // clock, time limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #500_000;
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // filter model
  // --------------------------------------------------------------------------
  function automatic logic fill_byte(input logic [7:0] b);
    return (b == SIGN_ZERO) || (b == SIGN_ONES);
  endfunction

  task automatic clear_window();
    int i;
    for (i = 0; i < WinLen; i++) win[i] = 8'h00;
    held = 0;
    call_mask = 3'd0;
    gap = 2'd0;
    pos = 32'd0;
  endtask

  task automatic emit(input logic [7:0] b);
    out_word_t w;
    w.data = b;
    w.last = 1'b0;
    step_words.push_back(w);
  endtask

  // head goes out unchanged, window slides by one
  task automatic shift_head();
    int i;
    emit(win[0]);
    for (i = 0; i < WinLen - 1; i++) win[i] = win[i + 1];
    win[WinLen - 1] = 8'h00;
    held = WinLen - 1;
    pos = pos + 32'd1;
  endtask

  task automatic filter_byte(input logic [7:0] b, input logic l);
    logic [7:0]  head;
    logic [7:0]  probe;
    logic [31:0] v;
    logic [31:0] cur;
    logic [31:0] flip;
    logic [4:0]  sh;
    logic        skip;
    int          idx;
    int          i;
    step_words.delete();
    if (held >= WinLen) held = WinLen - 1;
    win[held] = b;
    held = held + 1;

    if (held == WinLen) begin
      head = win[0];
      if ((head & OPC_MASK) != OPC_CALL) begin
        if (gap < GAP_MAX) gap = gap + 2'd1;
        shift_head();
      end else begin
        skip = 1'b0;
        if (gap == GAP_MAX) begin
          call_mask = 3'd0;
        end else begin
          call_mask = call_mask >> gap;
          idx = ((call_mask >> 1) + 1) & 3;
          if (call_mask != 3'd0 &&
              (call_mask > 3'd4 || call_mask == 3'd3 || fill_byte(win[idx])))
            skip = 1'b1;
        end
        gap = 2'd0;

        if (!skip && fill_byte(win[4])) begin
          v = {win[4], win[3], win[2], win[1]};
          cur = base + POS_BIAS + pos;
          v = fwd ? v + cur : v - cur;
          if (call_mask != 3'd0) begin
            // second pass keyed on the byte the mask points at
            sh = {call_mask[2:1], 3'b000};
            probe = 8'(v >> sh);
            if (fill_byte(probe)) begin
              flip = (32'h0000_0100 << sh) - 32'd1;
              v = v ^ flip;
              v = fwd ? v + cur : v - cur;
            end
            call_mask = 3'd0;
          end
          emit(head);
          emit(v[7:0]);
          emit(v[15:8]);
          emit(v[23:16]);
          emit(v[24] ? SIGN_ONES : SIGN_ZERO);
          for (i = 0; i < WinLen; i++) win[i] = 8'h00;
          held = 0;
          pos = pos + WinLen;
        end else begin
          call_mask = (call_mask >> 1) | MASK_SEEN;
          shift_head();
        end
      end
    end

    // end of stream: flush whatever is held, tag the final word
    if (l) begin
      for (i = 0; i < held; i++) emit(win[i]);
      if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
      clear_window();
    end
  endtask

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    fail_count = fail_count + 1;
  endtask

  always @(posedge clk) begin : out_check
    out_word_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_out.size() == 0) begin
        report($sformatf("word %h/%b with nothing owed", m_axis_tdata, m_axis_tlast));
      end else begin
        w = pending_out.pop_front();
        if (m_axis_tdata !== w.data)
          report($sformatf("out_byte %h, want %h", m_axis_tdata, w.data));
        if (m_axis_tlast !== w.last)
          report($sformatf("out_last %b, want %b", m_axis_tlast, w.last));
      end
    end
  end

  // output side: random stall bursts, none while calm is set
  initial begin : sink_pacing
    int hold;
    hold = 0;
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold = hold - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers (all entered and left at a falling edge)
  // --------------------------------------------------------------------------
  function automatic stim_row_t word_row(input logic [7:0] b, input logic l);
    stim_row_t r;
    r = '0;
    r.b = b;
    r.l = l;
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic [7:0] b, input logic l,
                                          input logic [2:0] n, input logic [39:0] outs);
    stim_row_t r;
    r = word_row(b, l);
    r.typed = 1'b1;
    r.n = n;
    r.outs = outs;
    return r;
  endfunction

  // offer one word, wait for the handshake, then log what it owes
  task automatic push_word(input stim_row_t r);
    out_word_t w;
    int gap_len;
    int k;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap_len = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap_len) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r.b;
    s_axis_tlast  <= r.l;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    filter_byte(r.b, r.l);
    if (r.typed) begin
      for (k = 0; k < r.n; k++) begin
        w.data = r.outs[k];
        w.last = r.l && (k == r.n - 1);
        pending_out.push_back(w);
      end
    end else begin
      foreach (step_words[k]) pending_out.push_back(step_words[k]);
    end
    @(negedge clk);
  endtask

  // drain everything owed, then give the pipeline time to go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic set_config(input logic [31:0] dir_word, input logic [31:0] offset_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DIRECTION;
    cfg_data  <= dir_word;
    @(negedge clk);
    cfg_index <= REG_START_OFFSET;
    cfg_data  <= offset_word;
    @(negedge clk);
    cfg_we <= 1'b0;
    fwd  = dir_word[0];   // upper bits of the direction word are dropped
    base = offset_word;
  endtask

  // random stream content, biased toward call opcodes and well-formed calls
  task automatic fill_stream(input int len, ref logic [7:0] bytes[$]);
    int r;
    bytes.delete();
    while (bytes.size() < len) begin
      r = $urandom_range(0, 99);
      if (r < 30 && len - bytes.size() >= WinLen) begin
        bytes.push_back(OPC_CALL | 8'($urandom_range(0, 1)));
        repeat (3) bytes.push_back(8'($urandom));
        bytes.push_back($urandom_range(0, 1) ? SIGN_ONES : SIGN_ZERO);
      end else if (r < 50) begin
        bytes.push_back(OPC_CALL | 8'($urandom_range(0, 1)));
      end else if (r < 65) begin
        bytes.push_back($urandom_range(0, 1) ? SIGN_ONES : SIGN_ZERO);
      end else begin
        bytes.push_back(8'($urandom));
      end
    end
  endtask

  // streams of mostly 5..40 bytes; leave_open keeps the final one unterminated
  // so the next register write lands mid-stream
  task automatic run_streams(input int n_words, input bit leave_open);
    logic [7:0] bytes[$];
    int sent;
    int len;
    int i;
    bit close;
    sent = 0;
    while (sent < n_words) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
      if (len > n_words - sent) len = n_words - sent;
      fill_stream(len, bytes);
      close = !(leave_open && sent + len >= n_words);
      for (i = 0; i < len; i++) push_word(word_row(bytes[i], close && (i == len - 1)));
      sent = sent + len;
    end
    settle();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int r;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_DIRECTION;
    cfg_data      = 32'd0;
    calm          = 1'b0;
    fail_count    = 0;
    fwd           = 1'b0;
    base          = 32'd0;
    clear_window();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, reset settings (inverse, offset 0)
    // short stream: nothing until the last word, then both bytes unchanged
    plan[0]  = known_row(8'h00, 1'b0, 3'd0, 40'h0);
    plan[1]  = known_row(8'hFF, 1'b1, 3'd2, {8'hFF, 8'h00});
    // lone call opcode as a one-byte stream
    plan[2]  = known_row(8'hE8, 1'b1, 3'd1, {8'hE8});
    // E8 with positive displacement, converted
    plan[3]  = word_row(8'hE8, 1'b0);
    plan[4]  = word_row(8'h10, 1'b0);
    plan[5]  = word_row(8'h00, 1'b0);
    plan[6]  = word_row(8'h00, 1'b0);
    plan[7]  = word_row(8'h00, 1'b0);
    // E9 with negative displacement, converted
    plan[8]  = word_row(8'hE9, 1'b0);
    plan[9]  = word_row(8'hF0, 1'b0);
    plan[10] = word_row(8'hFF, 1'b0);
    plan[11] = word_row(8'hFF, 1'b0);
    plan[12] = word_row(8'hFF, 1'b0);
    // back-to-back calls: mask skips and second correction
    plan[13] = word_row(8'hE8, 1'b0);
    plan[14] = word_row(8'hE8, 1'b0);
    plan[15] = word_row(8'h00, 1'b0);
    plan[16] = word_row(8'hFF, 1'b0);
    plan[17] = word_row(8'h00, 1'b0);
    plan[18] = word_row(8'hE9, 1'b0);
    plan[19] = word_row(8'h7F, 1'b0);
    plan[20] = word_row(8'h80, 1'b0);
    // call whose fifth byte is not a sign byte, then flush on last
    plan[21] = word_row(8'hE8, 1'b0);
    plan[22] = word_row(8'h12, 1'b0);
    plan[23] = word_row(8'hFF, 1'b0);
    plan[24] = word_row(8'hFE, 1'b1);
    for (r = 0; r < 25; r++) push_word(plan[r]);
    settle();

    // random part under several settings; two phases end mid-stream so the
    // following write changes registers inside an open stream
    set_config(32'h0000_0001, 32'h0000_0000);
    run_streams(100, 1'b1);
    set_config(32'hFFFF_FFFE, 32'hFFFF_FFFF);   // direction 0, wide value
    run_streams(100, 1'b0);
    set_config(32'h8000_0003, 32'hFFFF_FFF8);   // direction 1, offset near wrap
    run_streams(100, 1'b1);
    set_config($urandom, $urandom);
    calm = 1'b1;
    run_streams(80, 1'b0);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
